>>> hdl/frd_pkg.sv
// Shared types and constants for the frame rate decimator.
package frd_pkg;

   localparam int TIME_W     = 32;
   localparam int CMD_W      = 2;
   localparam int TARGET_W   = 5;
   localparam int RATE_W     = 24;
   localparam int FRAC_W     = 8;
   localparam int IN_W       = RATE_W + 1 - FRAC_W;
   localparam int SCALE_W    = 18;
   localparam int PROD_W     = TIME_W + SCALE_W;
   localparam int DIV_STEPS  = RATE_W;
   localparam int DIV_CNT_W  = 5;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CMD_W-1:0] CMD_FRAME   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REPLAN  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 2'd1;

   localparam logic [TARGET_W-1:0] TARGET_MIN   = 5'd1;
   localparam logic [TARGET_W-1:0] TARGET_MAX   = 5'd30;
   localparam logic [TARGET_W-1:0] TARGET_RESET = 5'd30;
   localparam logic [TIME_W-1:0]   INTERVAL_RESET = 32'd5000;

   // frames * 1000 ms/s * 256 (Q16.8)
   localparam logic [SCALE_W-1:0]  RATE_SCALE   = 18'd256000;
   localparam logic [RATE_W-1:0]   RATE_ROUND   = 24'd128;
   localparam logic [RATE_W-1:0]   DIFF_BIG     = 24'd512;
   localparam logic [RATE_W-1:0]   DIFF_SMALL   = 24'd128;
   localparam logic [RATE_W-1:0]   RATE_LOW     = 24'd256;

   typedef struct packed {
      logic load;        // latch the accepted item
      logic exec;        // decode the command, count the frame
      logic measure;     // close the interval, form the product
      logic sat_check;   // saturate or start the divide
      logic div_step;    // one quotient bit
      logic rate_write;  // store the new rate
      logic plan_init;   // start a replan
      logic plan_step;   // one mask slot
      logic slot_adv;    // advance the slot pointer
      logic out_load;    // fill the result register
   } frd_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic measure_due;
      logic saturate;
      logic div_last;
      logic need_replan;
      logic plan_fill;
      logic plan_last;
   } frd_stat_type;

endpackage

>>> hdl/frame_rate_decimator.sv
// Top level of the frame rate decimator: controller plus datapath.
//
// Each req item carries a command and the millisecond tick counter. A frame
// command returns whether the frame is dropped, whether it closed a rate
// measurement interval, and the latest measured rate in Q16.8 frames per
// second. Restart and replan commands return the rate with both flags low.
// Registers are to be written through the csr port only while no item is in
// flight; the block itself does not enforce this. One item is processed at a
// time, and its result appears in the same cycle that the next item can be
// taken. A frame that closes an interval also runs a saturation check, 24
// serial divide steps and a rate write, or only the check and the rate write
// when the quotient saturates. A replan runs a setup step and then a step for
// each mask slot, or only the setup step when every slot is kept.
// The result sits in an output register: the next item is accepted while it
// waits, and a stalled receiver holds the block only when a second result is
// ready. Reset restores the target of 30 frames/s, a 5000 ms interval,
// cleared statistics and a mask that keeps every frame.
module frame_rate_decimator #(
   parameter int MASK_SLOTS = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [frd_pkg::CMD_W-1:0]     req_cmd,
   input  logic [frd_pkg::TIME_W-1:0]    req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_skip_frame,
   output logic                          rsp_stat_updated,
   output logic [frd_pkg::RATE_W-1:0]    rsp_measured_rate,
   input  logic                          csr_wen,
   input  logic [frd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [frd_pkg::TIME_W-1:0]    csr_wdata
);
   import frd_pkg::*;

   frd_cmd_type  ctrl;
   frd_stat_type stat;

   frd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   frd_datapath #(
      .MASK_SLOTS (MASK_SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .req_cmd           (req_cmd),
      .req_now_ms        (req_now_ms),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_skip_frame    (rsp_skip_frame),
      .rsp_stat_updated  (rsp_stat_updated),
      .rsp_measured_rate (rsp_measured_rate)
   );

endmodule

>>> hdl/frd_datapath.sv
// Datapath: statistics, serial divider, mask planner, slot pointer and result register.
module frd_datapath #(
   parameter int MASK_SLOTS = 30
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  frd_pkg::frd_cmd_type                 ctrl,
   output frd_pkg::frd_stat_type                stat,
   input  logic [frd_pkg::CMD_W-1:0]            req_cmd,
   input  logic [frd_pkg::TIME_W-1:0]           req_now_ms,
   input  logic                                 csr_wen,
   input  logic [frd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [frd_pkg::TIME_W-1:0]           csr_wdata,
   output logic                                 rsp_skip_frame,
   output logic                                 rsp_stat_updated,
   output logic [frd_pkg::RATE_W-1:0]           rsp_measured_rate
);
   import frd_pkg::*;

   localparam int IDX_W = $clog2(MASK_SLOTS);
   localparam int LEN_W = $clog2(MASK_SLOTS + 1);
   localparam int ACC_W = $clog2((MASK_SLOTS + 1) * MASK_SLOTS + 1);

   // configuration
   logic [TARGET_W-1:0] target_ff;
   logic [TIME_W-1:0]   interval_ff;

   // statistics and mask state
   logic [TIME_W-1:0]     start_ff;
   logic [TIME_W-1:0]     frames_ff;
   logic [RATE_W-1:0]     rate_ff;
   logic [IDX_W-1:0]      slot_pos_ff;
   logic [LEN_W-1:0]      slot_len_ff;
   logic [MASK_SLOTS-1:0] mask_ff;
   logic                  skip_ff;
   logic                  upd_ff;

   // working registers
   logic [CMD_W-1:0]     cmd_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [TIME_W-1:0]    elapsed_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [TIME_W-1:0]    rem_ff;
   logic [DIV_STEPS-1:0] dvd_ff;
   logic [RATE_W-1:0]    quot_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [ACC_W-1:0]     acc_a_ff;
   logic [ACC_W-1:0]     acc_b_ff;
   logic [IDX_W-1:0]     plan_idx_ff;

   logic [TIME_W-1:0]  frames_inc;
   logic [PROD_W-1:0]  prod_c;
   logic [TIME_W:0]    trial;
   logic               trial_fits;
   logic [RATE_W-1:0]  rate_diff;
   logic [RATE_W:0]    round_sum;
   logic [IN_W-1:0]    in_rate;
   logic               keep;
   logic [ACC_W-1:0]   acc_gap;
   logic [LEN_W-1:0]   pos_inc;
   logic [IDX_W-1:0]   pos_next;

   assign frames_inc = (frames_ff == '1) ? frames_ff : frames_ff + 1'b1;
   assign prod_c     = PROD_W'(frames_ff) * PROD_W'(RATE_SCALE);

   assign trial      = {rem_ff, dvd_ff[DIV_STEPS-1]};
   assign trial_fits = trial >= {1'b0, elapsed_ff};

   assign rate_diff  = (quot_ff >= rate_ff) ? quot_ff - rate_ff : rate_ff - quot_ff;

   assign round_sum  = {1'b0, rate_ff} + {1'b0, RATE_ROUND};
   assign in_rate    = round_sum[RATE_W:FRAC_W];

   assign acc_gap    = acc_a_ff - acc_b_ff;
   assign keep       = (acc_a_ff >= acc_b_ff) && (acc_gap < ACC_W'(target_ff));

   assign pos_inc    = LEN_W'(slot_pos_ff) + LEN_W'(1);
   assign pos_next   = (pos_inc >= slot_len_ff) ? '0 : IDX_W'(pos_inc);

   always_comb begin
      stat.cmd         = cmd_ff;
      stat.measure_due = (elapsed_ff >= interval_ff) && (elapsed_ff != '0);
      stat.saturate    = TIME_W'(prod_ff[PROD_W-1:DIV_STEPS]) >= elapsed_ff;
      stat.div_last    = div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
      stat.need_replan = (rate_diff >= DIFF_BIG) ||
                         ((rate_ff <= RATE_LOW) && (rate_diff >= DIFF_SMALL));
      stat.plan_fill   = (in_rate == '0) || (in_rate > IN_W'(MASK_SLOTS)) ||
                         (in_rate <= IN_W'(target_ff));
      stat.plan_last   = plan_idx_ff == IDX_W'(MASK_SLOTS - 1);
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= TARGET_RESET;
         interval_ff <= INTERVAL_RESET;
         start_ff    <= '0;
         frames_ff   <= '0;
         rate_ff     <= '0;
         slot_pos_ff <= '0;
         slot_len_ff <= LEN_W'(MASK_SLOTS);
         mask_ff     <= '1;
         skip_ff     <= 1'b0;
         upd_ff      <= 1'b0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_TARGET) begin
               if ((csr_wdata[TARGET_W-1:0] >= TARGET_MIN) &&
                   (csr_wdata[TARGET_W-1:0] <= TARGET_MAX)) begin
                  target_ff <= csr_wdata[TARGET_W-1:0];
               end
            end else if (csr_index == CSR_INTERVAL) begin
               if (csr_wdata != '0) begin
                  interval_ff <= csr_wdata;
               end
            end
         end
         if (ctrl.exec) begin
            skip_ff <= 1'b0;
            upd_ff  <= 1'b0;
            if (cmd_ff == CMD_FRAME) begin
               frames_ff <= frames_inc;
            end else if (cmd_ff == CMD_RESTART) begin
               start_ff  <= now_ff;
               frames_ff <= '0;
               rate_ff   <= '0;
            end
         end
         if (ctrl.measure) begin
            frames_ff <= '0;
            start_ff  <= now_ff;
         end
         if (ctrl.rate_write) begin
            rate_ff <= quot_ff;
            upd_ff  <= 1'b1;
         end
         if (ctrl.plan_init) begin
            slot_pos_ff <= '0;
            if (stat.plan_fill) begin
               mask_ff     <= '1;
               slot_len_ff <= LEN_W'(MASK_SLOTS);
            end else begin
               slot_len_ff <= LEN_W'(in_rate);
            end
         end
         if (ctrl.plan_step) begin
            mask_ff[plan_idx_ff] <= keep;
         end
         if (ctrl.slot_adv) begin
            slot_pos_ff <= pos_next;
            skip_ff     <= ~mask_ff[pos_next];
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= req_cmd;
         now_ff <= req_now_ms;
      end
      if (ctrl.exec) begin
         elapsed_ff <= now_ff - start_ff;
      end
      if (ctrl.measure) begin
         prod_ff <= prod_c;
      end
      if (ctrl.sat_check) begin
         rem_ff     <= TIME_W'(prod_ff[PROD_W-1:DIV_STEPS]);
         dvd_ff     <= prod_ff[DIV_STEPS-1:0];
         div_cnt_ff <= '0;
         if (stat.saturate) begin
            quot_ff <= '1;
         end
      end
      if (ctrl.div_step) begin
         rem_ff     <= trial_fits ? TIME_W'(trial - {1'b0, elapsed_ff}) : trial[TIME_W-1:0];
         dvd_ff     <= {dvd_ff[DIV_STEPS-2:0], 1'b0};
         quot_ff    <= {quot_ff[RATE_W-2:0], trial_fits};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (ctrl.plan_init) begin
         acc_a_ff    <= ACC_W'(in_rate);
         acc_b_ff    <= '0;
         plan_idx_ff <= '0;
      end
      if (ctrl.plan_step) begin
         // next kept slot needs k*in to move on by one frame period
         if (keep) begin
            acc_a_ff <= acc_a_ff + ACC_W'(slot_len_ff);
         end
         acc_b_ff    <= acc_b_ff + ACC_W'(target_ff);
         plan_idx_ff <= plan_idx_ff + 1'b1;
      end
      if (ctrl.out_load) begin
         rsp_skip_frame    <= skip_ff;
         rsp_stat_updated  <= upd_ff;
         rsp_measured_rate <= rate_ff;
      end
   end

endmodule

>>> hdl/frd_ctrl.sv
// Controller: sequences one item through measure, divide, replan and slot steps.
module frd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  frd_pkg::frd_stat_type stat,
   output frd_pkg::frd_cmd_type  ctrl
);
   import frd_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EXEC  = 4'd1;
   localparam logic [3:0] S_MEAS  = 4'd2;
   localparam logic [3:0] S_SAT   = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_RATE  = 4'd5;
   localparam logic [3:0] S_PINIT = 4'd6;
   localparam logic [3:0] S_PLAN  = 4'd7;
   localparam logic [3:0] S_SLOT  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctrl         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            ctrl.exec = 1'b1;
            case (stat.cmd)
               CMD_FRAME:  state_in = S_MEAS;
               CMD_REPLAN: state_in = S_PINIT;
               default:    state_in = S_DONE;
            endcase
         end
         S_MEAS: begin
            if (stat.measure_due) begin
               ctrl.measure = 1'b1;
               state_in     = S_SAT;
            end else begin
               state_in = S_SLOT;
            end
         end
         S_SAT: begin
            ctrl.sat_check = 1'b1;
            state_in       = stat.saturate ? S_RATE : S_DIV;
         end
         S_DIV: begin
            ctrl.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_RATE;
            end
         end
         S_RATE: begin
            ctrl.rate_write = 1'b1;
            state_in        = stat.need_replan ? S_PINIT : S_SLOT;
         end
         S_PINIT: begin
            ctrl.plan_init = 1'b1;
            if (stat.plan_fill) begin
               state_in = (stat.cmd == CMD_FRAME) ? S_SLOT : S_DONE;
            end else begin
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            ctrl.plan_step = 1'b1;
            if (stat.plan_last) begin
               state_in = (stat.cmd == CMD_FRAME) ? S_SLOT : S_DONE;
            end
         end
         S_SLOT: begin
            ctrl.slot_adv = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // hold until the result register is free
            if (out_free) begin
               ctrl.out_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> dv/frd_frame_check.sv
// Result checker for the frame rate decimator: predicts every item and compares results.
module frd_frame_check #(
   parameter int MASK_SLOTS = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [frd_pkg::CMD_W-1:0]     req_cmd,
   input  logic [frd_pkg::TIME_W-1:0]    req_now_ms,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_skip_frame,
   input  logic                          rsp_stat_updated,
   input  logic [frd_pkg::RATE_W-1:0]    rsp_measured_rate,
   input  logic                          csr_wen,
   input  logic [frd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [frd_pkg::TIME_W-1:0]    csr_wdata,
   output int                            fail_count,
   output int                            results_due,
   output int                            measure_count,
   output int                            replan_count,
   output int                            drop_count
);
   import frd_pkg::*;

   localparam int SLOT_W = $clog2(MASK_SLOTS + 1);
   localparam int MAX_REPORTS = 40;
   localparam logic [RATE_W-1:0] RATE_FULL = '1;

   typedef struct packed {
      logic              skip;
      logic              updated;
      logic [RATE_W-1:0] rate;
   } verdict_type;

   verdict_type verdict_q[$];
   int          results_seen;

   logic [TARGET_W-1:0]   target_rate;
   logic [TIME_W-1:0]     interval_ms;
   logic [TIME_W-1:0]     interval_start;
   logic [TIME_W-1:0]     frames_seen;
   logic [RATE_W-1:0]     rate_q8;
   logic [SLOT_W-1:0]     slot_pos;
   logic [SLOT_W-1:0]     slot_len;
   logic [MASK_SLOTS-1:0] keep_mask;

   task automatic report_mismatch(input string msg);
      if (fail_count < MAX_REPORTS)
         $display("[%0t] result %0d: %s", $time, results_seen, msg);
      fail_count++;
   endtask

   function automatic void reset_model();
      target_rate    = TARGET_RESET;
      interval_ms    = INTERVAL_RESET;
      interval_start = '0;
      frames_seen    = '0;
      rate_q8        = '0;
      slot_pos       = '0;
      slot_len       = SLOT_W'(MASK_SLOTS);
      keep_mask      = '1;
   endfunction

   // Spread target_rate kept frames evenly over in_fps slots.
   function automatic void plan_keep_mask();
      int unsigned in_fps, k, a, b, i;
      in_fps = (32'(rate_q8) + 32'(RATE_ROUND)) >> FRAC_W;
      slot_pos = '0;
      replan_count++;
      if (in_fps == 0 || in_fps > MASK_SLOTS || in_fps <= target_rate) begin
         keep_mask = '1;
         slot_len  = SLOT_W'(MASK_SLOTS);
      end else begin
         slot_len = SLOT_W'(in_fps);
         k = 1;
         for (i = 0; i < MASK_SLOTS; i++) begin
            a = k * in_fps;
            b = i * target_rate;
            keep_mask[i] = (a >= b) && (a - b < target_rate);
            if (keep_mask[i])
               k++;
         end
      end
   endfunction

   function automatic void write_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [TIME_W-1:0] data);
      case (idx)
         CSR_TARGET: begin
            if (data[TARGET_W-1:0] >= TARGET_MIN && data[TARGET_W-1:0] <= TARGET_MAX)
               target_rate = data[TARGET_W-1:0];
         end
         CSR_INTERVAL: begin
            if (data != '0)
               interval_ms = data;
         end
         default: ;
      endcase
   endfunction

   function automatic verdict_type predict_verdict(input logic [CMD_W-1:0] cmd,
                                                   input logic [TIME_W-1:0] now);
      verdict_type       v;
      logic [TIME_W-1:0] elapsed;
      logic [63:0]       quot;
      logic [RATE_W-1:0] old_rate;
      logic [RATE_W-1:0] diff;
      v = '0;
      case (cmd)
         CMD_FRAME: begin
            elapsed = now - interval_start;
            if (frames_seen != '1)
               frames_seen++;
            if (elapsed >= interval_ms && elapsed != '0) begin
               old_rate = rate_q8;
               quot = (64'(frames_seen) * 64'(RATE_SCALE)) / 64'(elapsed);
               rate_q8 = (quot > 64'(RATE_FULL)) ? RATE_FULL : quot[RATE_W-1:0];
               frames_seen    = '0;
               interval_start = now;
               v.updated      = 1'b1;
               measure_count++;
               diff = (rate_q8 >= old_rate) ? rate_q8 - old_rate : old_rate - rate_q8;
               if (diff >= DIFF_BIG || (old_rate <= RATE_LOW && diff >= DIFF_SMALL))
                  plan_keep_mask();
            end
            slot_pos = (slot_pos + 1'b1 >= slot_len) ? '0 : slot_pos + 1'b1;
            v.skip = !keep_mask[slot_pos];
            if (v.skip)
               drop_count++;
         end
         CMD_RESTART: begin
            interval_start = now;
            frames_seen    = '0;
            rate_q8        = '0;
         end
         CMD_REPLAN: plan_keep_mask();
         default: ;
      endcase
      v.rate = rate_q8;
      return v;
   endfunction

   task automatic check_result();
      verdict_type want;
      results_seen++;
      if (verdict_q.size() == 0) begin
         report_mismatch($sformatf("result with no item pending: skip %0b upd %0b rate %0d",
                                   rsp_skip_frame, rsp_stat_updated, rsp_measured_rate));
         return;
      end
      want = verdict_q.pop_front();
      if (rsp_skip_frame !== want.skip)
         report_mismatch($sformatf("skip_frame expected %0b, got %0b",
                                   want.skip, rsp_skip_frame));
      if (rsp_stat_updated !== want.updated)
         report_mismatch($sformatf("stat_updated expected %0b, got %0b",
                                   want.updated, rsp_stat_updated));
      if (rsp_measured_rate !== want.rate)
         report_mismatch($sformatf("measured_rate expected %0d, got %0d",
                                   want.rate, rsp_measured_rate));
   endtask

   // Check results before predicting, so a result never pairs with a same-edge item.
   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         verdict_q.delete();
         results_seen  = 0;
         fail_count    = 0;
         measure_count = 0;
         replan_count  = 0;
         drop_count    = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_result();
         if (csr_wen)
            write_register(csr_index, csr_wdata);
         if (req_valid && req_ready)
            verdict_q.push_back(predict_verdict(req_cmd, req_now_ms));
      end
      results_due <= verdict_q.size();
   end

endmodule

>>> dv/tb_top.sv
// Top of the frame rate decimator testbench: clock, reset, stimulus and verdict.
module tb_top;
   import frd_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE     = 2'd3;
   localparam int                   SEG_ITEMS    = 64;
   localparam int                   HOLD_CYCLES  = 400;
   localparam int                   STALL_LIMIT  = 3000;
   localparam int                   DRAIN_CYCLES = 100;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_cmd = '0;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_skip_frame;
   logic                 rsp_stat_updated;
   logic [RATE_W-1:0]    rsp_measured_rate;
   logic                 csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]    csr_wdata = '0;

   int fail_count;
   int results_due;
   int measure_count;
   int replan_count;
   int drop_count;

   int send_idle_pct = 12;
   int recv_idle_pct = 51;
   int ready_hold_cycles = 0;
   int useful_items = 0;
   int quiet_cycles = 0;

   frame_rate_decimator dut (.*);

   frd_frame_check frame_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, plus one long counted hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (ready_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (ready_hold_cycles) @(posedge clock);
            ready_hold_cycles = 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Abort when no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("frame_rate_decimator regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd != CMD_UNUSED)
         useful_items++;
   endtask

   // Drop valid and hold until every predicted result has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // Write both registers, then poke an unmapped index.
   task automatic set_config(input logic [TARGET_W-1:0] tgt, input logic [TIME_W-1:0] span);
      csr_wen   <= 1'b1;
      csr_index <= CSR_TARGET;
      csr_wdata <= {27'($urandom()), tgt};
      @(posedge clock);
      csr_index <= CSR_INTERVAL;
      csr_wdata <= span;
      @(posedge clock);
      csr_index <= $urandom_range(1) ? CSR_SPARE : CSR_NONE;
      csr_wdata <= $urandom();
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin
      int                k, seg, seg_start, pick, fps;
      int unsigned       gap;
      logic [TARGET_W-1:0] tgt;
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] cursor;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: time extremes, wrap, unused command, fill cases, planned mask.
      send_item(CMD_FRAME, '0);
      send_item(CMD_FRAME, '1);
      send_item(CMD_UNUSED, $urandom());
      send_item(CMD_REPLAN, '0);
      send_item(CMD_RESTART, 32'hFFFF_FFF0);
      send_item(CMD_FRAME, 32'd4992);
      wait_idle();
      set_config('0, '0);
      set_config(5'd31, 32'd1000);
      send_item(CMD_RESTART, 32'd10000);
      for (k = 1; k <= 10; k++)
         send_item(CMD_FRAME, 32'd10000 + 32'(100 * k));
      send_item(CMD_REPLAN, '0);
      wait_idle();
      set_config(TARGET_MIN, 32'd1000);
      send_item(CMD_REPLAN, '0);
      for (k = 1; k <= 5; k++)
         send_item(CMD_FRAME, 32'd11000 + 32'(100 * k));

      cursor = 32'd12000;
      for (seg = 0; seg < 6; seg++) begin
         wait_idle();
         case (seg)
            0: begin
               tgt  = TARGET_MAX;
               span = 32'd250;
            end
            1: begin
               tgt  = TARGET_MIN;
               span = '1;
            end
            2: begin
               tgt  = 5'($urandom_range(1, 30));
               span = 32'd1;
            end
            default: begin
               tgt  = 5'($urandom_range(1, 30));
               span = $urandom_range(100, 800);
            end
         endcase
         set_config(tgt, span);
         send_idle_pct = (seg < 2) ? 12 : (seg < 4) ? 51 : 0;
         recv_idle_pct = (seg < 2) ? 51 : (seg < 4) ? 12 : 0;
         if (seg == 4)
            ready_hold_cycles = HOLD_CYCLES;
         seg_start = useful_items;
         while (useful_items - seg_start < SEG_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               // steady stream at one frame rate with jitter
               fps = $urandom_range(1, 40);
               gap = 1000 / fps;
               repeat ($urandom_range(6, 24)) begin
                  cursor += gap - gap / 8 + $urandom_range(0, gap / 4);
                  send_item(CMD_FRAME, cursor);
               end
            end else if (pick < 72) begin
               // burst of frames on one tick, then close the interval
               send_item(CMD_RESTART, cursor);
               repeat ($urandom_range(4, 20)) send_item(CMD_FRAME, cursor);
               cursor += span;
               send_item(CMD_FRAME, cursor);
            end else if (pick < 84) begin
               send_item($urandom_range(1) ? CMD_REPLAN : CMD_RESTART, cursor);
            end else if (pick < 95) begin
               if ($urandom_range(1))
                  cursor = $urandom();
               send_item(2'($urandom_range(0, 2)), $urandom());
            end else begin
               send_item(CMD_UNUSED, $urandom());
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d items over six register settings, three idle mixes and a long",
               useful_items);
      $display("receiver hold-off: %0d rate measurements, %0d mask replans, %0d dropped frames.",
               measure_count, replan_count, drop_count);
      if (fail_count == 0)
         $display("frame_rate_decimator regression: pass");
      else
         $display("frame_rate_decimator regression: fail");
      $finish;
   end

endmodule
